/* rtl/bqsg_pkg.sv */
// ----------------------------------------------------------------------------
// bqsg_pkg: shared types and constants
// Payload structs, the front-to-back job record and fixed-point constants of
// the bilinear quadrilateral shape gradient core.
// ----------------------------------------------------------------------------
package bqsg_pkg;

  // Input beat: particle position and cell bounds, all Q16.16.
  typedef struct packed {
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic signed [31:0] cell_x_low;
    logic signed [31:0] cell_x_high;
    logic signed [31:0] cell_y_low;
    logic signed [31:0] cell_y_high;
  } particle_t;

  // Result beat: one node of one particle.
  typedef struct packed {
    logic        [1:0]  node_number;
    logic        [30:0] weight;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] xi_coord;
    logic signed [31:0] eta_coord;
    logic               degenerate;
    logic               last_node;
  } node_t;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic               degenerate;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [34:0] num_x;
    logic signed [34:0] num_y;
  } job_t;

  // Divider geometry: 66-bit dividend, 34-bit divisor, 32 quotient bits.
  localparam int DIV_STEPS = 32;
  localparam int NUM_W     = 66;
  localparam int DEN_W     = 34;

  localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Register map.
  localparam logic REG_WEIGHT_FLOOR = 1'b0;

  // Magnitude of a 35-bit signed value (never larger than 2^34).
  function automatic logic [34:0] mag35(input logic signed [34:0] v);
    mag35 = v[34] ? 35'(-v) : 35'(v);
  endfunction

endpackage

/* rtl/bqsg_front.sv */
// ----------------------------------------------------------------------------
// bqsg_front: particle classifier
// Forms cell width, height and centered numerators and flags degenerate cells.
// ----------------------------------------------------------------------------
module bqsg_front
  import bqsg_pkg::*;
(
  input  particle_t particle,
  output job_t      job
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;

  // Width and height of the cell, one bit wider than the bounds.
  assign dx = 33'(particle.cell_x_high) - 33'(particle.cell_x_low);
  assign dy = 33'(particle.cell_y_high) - 33'(particle.cell_y_low);

  // Numerators 2p - low - high, and the degenerate test.
  always_comb begin
    job.dx         = dx;
    job.dy         = dy;
    job.num_x      = (35'(particle.particle_x) <<< 1) - 35'(particle.cell_x_high)
                     - 35'(particle.cell_x_low);
    job.num_y      = (35'(particle.particle_y) <<< 1) - 35'(particle.cell_y_high)
                     - 35'(particle.cell_y_low);
    job.degenerate = (dx == '0) || (dy == '0);
  end

endmodule

/* rtl/bqsg_queue.sv */
// ----------------------------------------------------------------------------
// bqsg_queue: job queue
// Small register queue that decouples the classifier from the arithmetic back.
// ----------------------------------------------------------------------------
module bqsg_queue
  import bqsg_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/bqsg_div.sv */
// ----------------------------------------------------------------------------
// bqsg_div: restoring divider
// Produces 32 quotient bits, one per cycle, for a dividend whose upper part
// is already below the divisor.
// ----------------------------------------------------------------------------
module bqsg_div
  import bqsg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [31:0]      quot
);

  logic             busy;
  logic [4:0]       cnt;
  logic [DEN_W-1:0] rem;
  logic [31:0]      low;
  logic [DEN_W:0]   trial;

  assign trial = {rem, low[31]};

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= num[NUM_W-1:32];
        low  <= num[31:0];
      end else if (busy) begin
        low <= {low[30:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem  <= DEN_W'(trial - {1'b0, den});
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= trial[DEN_W-1:0];
          quot <= {quot[30:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/bqsg_back.sv */
// ----------------------------------------------------------------------------
// bqsg_back: arithmetic back end
// Sequences the natural-coordinate and gradient divisions on a shared divider,
// then forms and emits the four node results through an output register.
// ----------------------------------------------------------------------------
module bqsg_back
  import bqsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] weight_floor,
  input  job_t        job_in,
  input  logic        job_ready,
  output logic        job_pop,
  output node_t       node,
  output logic        node_valid,
  input  logic        node_stall
);

  typedef enum logic [3:0] {
    S_IDLE, S_XI, S_ETA, S_GEM, S_GEP, S_GXM, S_GXP, S_MUL, S_EMIT
  } state_t;

  // Gradient slots: factor 1-eta or 1+eta over dx, 1-xi or 1+xi over dy.
  localparam logic [1:0] G_EM = 2'd0;
  localparam logic [1:0] G_EP = 2'd1;
  localparam logic [1:0] G_XM = 2'd2;
  localparam logic [1:0] G_XP = 2'd3;

  state_t             state;
  job_t               job;
  logic               launched;
  logic signed [31:0] xi;
  logic signed [31:0] eta;
  logic [31:0]        g_v [4];
  logic               g_n [4];
  logic [63:0]        prod;
  logic               pneg;
  logic [1:0]         k;

  logic signed [34:0] sel_num;
  logic signed [32:0] sel_den;
  logic               is_nat;
  logic [34:0]        a;
  logic [32:0]        b;
  logic               neg;
  logic [NUM_W-1:0]   n;
  logic [DEN_W-1:0]   d;
  logic               nat_sat;
  logic               ovf;
  logic               div_start;
  logic               div_done;
  logic [31:0]        q;
  logic signed [31:0] nat_res;
  logic [31:0]        grad_v;

  logic signed [33:0] fxm, fxp, fem, fep, fxk, fek;
  logic [34:0]        fxa, fea;
  logic [64:0]        wsum;
  logic signed [33:0] ws;
  logic signed [33:0] wfl;
  logic [30:0]        wout;
  logic [1:0]         gx_i, gy_i;
  logic signed [31:0] gx, gy;
  logic               out_free;

  function automatic logic signed [31:0] grad_fin(input logic [31:0] v, input logic ng);
    if (ng) begin
      grad_fin = 32'(33'd0 - {1'b0, v});
    end else begin
      grad_fin = v[31] ? S32_MAX : $signed(v);
    end
  endfunction

  // Factors 1 -/+ xi and 1 -/+ eta in Q2.30.
  assign fxm = ONE_Q30 - 34'(xi);
  assign fxp = ONE_Q30 + 34'(xi);
  assign fem = ONE_Q30 - 34'(eta);
  assign fep = ONE_Q30 + 34'(eta);

  // Divider operand selection by step.
  always_comb begin
    is_nat  = 1'b0;
    sel_num = job.num_x;
    sel_den = job.dx;
    unique case (state)
      S_XI: begin
        is_nat = 1'b1;
      end
      S_ETA: begin
        is_nat  = 1'b1;
        sel_num = job.num_y;
        sel_den = job.dy;
      end
      S_GEM: sel_num = 35'(fem);
      S_GEP: sel_num = 35'(fep);
      S_GXM: begin
        sel_num = 35'(fxm);
        sel_den = job.dy;
      end
      S_GXP: begin
        sel_num = 35'(fxp);
        sel_den = job.dy;
      end
      default: ;
    endcase
    a   = mag35(sel_num);
    b   = sel_den[32] ? 33'(-sel_den) : 33'(sel_den);
    neg = sel_num[34] ^ sel_den[32];
    d   = {b, 1'b0};
    if (is_nat) begin
      n = {1'b0, a[33:0], 31'b0} + {33'b0, b};
    end else begin
      n = {30'b0, a[31:0], 2'b0} + {33'b0, b};
    end
    nat_sat = {1'b0, a[33:0]} >= {1'b0, b, 1'b0};
    ovf     = n[NUM_W-1:32] >= d;
  end

  assign div_start = !launched && (state == S_XI || state == S_ETA || state == S_GEM ||
                                   state == S_GEP || state == S_GXM || state == S_GXP);

  bqsg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (n),
    .den   (d),
    .done  (div_done),
    .quot  (q)
  );

  // Rounding and saturation of finished quotients.
  always_comb begin
    if (nat_sat) begin
      nat_res = neg ? S32_MIN : S32_MAX;
    end else if (neg) begin
      nat_res = 32'(33'd0 - {1'b0, q});
    end else begin
      nat_res = q[31] ? S32_MAX : $signed(q);
    end
    grad_v = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
  end

  // Per-node weight and gradient selection.
  always_comb begin
    fxk  = (k == 2'd1 || k == 2'd2) ? fxp : fxm;
    fek  = k[1] ? fep : fem;
    fxa  = mag35(35'(fxk));
    fea  = mag35(35'(fek));
    wsum = {1'b0, prod} + 65'h0_8000_0000;
    ws   = pneg ? 34'(-{1'b0, wsum[64:32]}) : 34'({1'b0, wsum[64:32]});
    wfl  = 34'({1'b0, weight_floor});
    if (ws < wfl) begin
      wout = weight_floor;
    end else if (ws > 34'sh0_7FFF_FFFF) begin
      wout = 31'h7FFF_FFFF;
    end else begin
      wout = ws[30:0];
    end
    gx_i = k[1] ? G_EP : G_EM;
    gy_i = (k == 2'd1 || k == 2'd2) ? G_XP : G_XM;
    gx   = grad_fin(g_v[gx_i], g_n[gx_i] ^ (k == 2'd0 || k == 2'd3));
    gy   = grad_fin(g_v[gy_i], g_n[gy_i] ^ !k[1]);
  end

  assign out_free = !node_valid || !node_stall;
  assign job_pop  = (state == S_IDLE) && job_ready;

  // Sequencer, working registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      launched   <= 1'b0;
      node_valid <= 1'b0;
      k          <= '0;
    end else begin
      // An accepted beat leaves unless the emit step refills the register.
      if (node_valid && !node_stall && state != S_EMIT) begin
        node_valid <= 1'b0;
      end
      if (div_start) begin
        launched <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (job_ready) begin
            job   <= job_in;
            k     <= '0;
            state <= job_in.degenerate ? S_MUL : S_XI;
          end
        end
        S_XI, S_ETA: begin
          if (div_done) begin
            launched <= 1'b0;
            if (state == S_XI) begin
              xi    <= nat_res;
              state <= S_ETA;
            end else begin
              eta   <= nat_res;
              state <= S_GEM;
            end
          end
        end
        S_GEM, S_GEP, S_GXM, S_GXP: begin
          if (div_done) begin
            launched <= 1'b0;
            unique case (state)
              S_GEM: begin
                g_v[G_EM] <= grad_v;
                g_n[G_EM] <= neg;
                state     <= S_GEP;
              end
              S_GEP: begin
                g_v[G_EP] <= grad_v;
                g_n[G_EP] <= neg;
                state     <= S_GXM;
              end
              S_GXM: begin
                g_v[G_XM] <= grad_v;
                g_n[G_XM] <= neg;
                state     <= S_GXP;
              end
              default: begin
                g_v[G_XP] <= grad_v;
                g_n[G_XP] <= neg;
                state     <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= fxa[31:0] * fea[31:0];
          pneg  <= fxk[33] ^ fek[33];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            node_valid       <= 1'b1;
            node.node_number <= k;
            node.last_node   <= (k == 2'd3);
            node.degenerate  <= job.degenerate;
            if (job.degenerate) begin
              node.weight    <= '0;
              node.grad_x    <= '0;
              node.grad_y    <= '0;
              node.xi_coord  <= '0;
              node.eta_coord <= '0;
            end else begin
              node.weight    <= wout;
              node.grad_x    <= gx;
              node.grad_y    <= gy;
              node.xi_coord  <= xi;
              node.eta_coord <= eta;
            end
            k     <= k + 1'b1;
            state <= (k == 2'd3) ? S_IDLE : S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bilinear_quad_shape_gradients_core.sv */
// A regular cell takes six divisions on one shared bit-serial divider before its
// first result beat is valid; a degenerate cell skips them. The back end works on
// one particle at a time while the queue takes new particles ahead of it, and each
// result beat comes from a multiply step and an emit step. Reset (rst, synchronous)
// empties the queue, idles the sequencer and clears weight_floor to zero.
// ----------------------------------------------------------------------------
// bilinear_quad_shape_gradients_core: top level
// Bilinear quadrilateral shape weights and gradients with an APB register port.
// ----------------------------------------------------------------------------
module bilinear_quad_shape_gradients_core
  import bqsg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        particle_valid,
  output logic        particle_stall,
  input  particle_t   particle,
  output logic        node_valid,
  input  logic        node_stall,
  output node_t       node,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0] weight_floor;
  job_t        job_new;
  job_t        job_head;
  logic        q_full;
  logic        q_empty;
  logic        job_pop;

  // Register port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WEIGHT_FLOOR) ? {1'b0, weight_floor} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_floor <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WEIGHT_FLOOR) begin
      weight_floor <= pwdata[30:0];
    end
  end

  assign particle_stall = q_full;

  bqsg_front u_front (
    .particle (particle),
    .job      (job_new)
  );

  bqsg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (particle_valid && !q_full),
    .push_data (job_new),
    .pop       (job_pop),
    .pop_data  (job_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bqsg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .weight_floor (weight_floor),
    .job_in       (job_head),
    .job_ready    (!q_empty),
    .job_pop      (job_pop),
    .node         (node),
    .node_valid   (node_valid),
    .node_stall   (node_stall)
  );

endmodule

/* rtl/bqsg_checker.sv */
// ----------------------------------------------------------------------------
// bqsg_checker: port checker
// Watches the top-level ports of the shape gradient core over time.
// ----------------------------------------------------------------------------
module bqsg_checker
  import bqsg_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  node_valid,
  input logic  node_stall,
  input node_t node,
  input logic  pready
);

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    node_valid && node_stall |=> node_valid && $stable(node))
    else $error("stalled result beat changed");

  // The run marker sits on the fourth node only.
  a_last: assert property (@(posedge clk) disable iff (rst)
    node_valid |-> (node.last_node == (node.node_number == 2'd3)))
    else $error("last_node does not match node 3");

  // A degenerate cell carries zero values.
  a_degen: assert property (@(posedge clk) disable iff (rst)
    node_valid && node.degenerate |-> node.weight == '0 && node.grad_x == '0 &&
    node.grad_y == '0 && node.xi_coord == '0 && node.eta_coord == '0)
    else $error("degenerate beat with nonzero values");

  // The register port never waits.
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind bilinear_quad_shape_gradients_core bqsg_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .node_valid (node_valid),
  .node_stall (node_stall),
  .node       (node),
  .pready     (pready)
);

/* dv/tb_bilinear_quad_shape_gradients_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_quad_shape_gradients_core: self-checking testbench
// Drives particle beats through a directed table and then random traffic under
// several weight floors, predicts the four node beats of each particle and
// compares every node beat field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module tb_bilinear_quad_shape_gradients_core;
  import bqsg_pkg::*;

  localparam int      WATCHDOG_LIMIT = 5000;
  localparam int      LONG_HOLD      = 600;
  localparam int      SETTLE_CYCLES  = 300;
  localparam int      RANDOM_ITEMS   = 31;
  localparam longint  SAT_MAX        = 64'sd2147483647;
  localparam longint  SAT_MIN        = -64'sd2147483648;
  localparam longint  Q30_ONE        = 64'sd1073741824;
  localparam logic [2:0] ADDR_WEIGHT_FLOOR = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_CENTER, ROW_DEGENERATE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    particle_t p;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        particle_valid = 1'b0;
  logic        particle_stall;
  particle_t   particle = '0;
  logic        node_valid;
  logic        node_stall = 1'b1;
  node_t       node;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state and the queue of node beats still owed by the core.
  logic [30:0] floor_model = '0;
  node_t       pending_nodes[$];
  int          error_count = 0;
  bit          quiet_mode = 1'b0;
  bit          hold_request = 1'b0;
  int          idle_cycles = 0;

  bilinear_quad_shape_gradients_core dut (
    .clk, .rst, .particle_valid, .particle_stall, .particle,
    .node_valid, .node_stall, .node,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // Round-to-nearest natural coordinate in Q2.30, saturated to 32 bits.
  function automatic longint natural_q30(longint num, longint den);
    bit neg;
    longint unsigned a, b, q, r;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    if (a >= 2 * b) return neg ? SAT_MIN : SAT_MAX;
    q = (a >= b) ? 1 : 0;
    r = a - q * b;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 1;
      end
    end
    r = r << 1;
    if (r >= b) q = q + 1;
    if (neg) return -longint'(q);
    return (q > longint'(SAT_MAX)) ? SAT_MAX : longint'(q);
  endfunction

  // Product of two Q2.30 factors divided by four, back in Q2.30.
  function automatic longint quarter_q30(longint p, longint q);
    longint unsigned m;
    longint v;
    m = longint'((p < 0) ? -p : p) * longint'((q < 0) ? -q : q);
    v = longint'((m + 64'h8000_0000) >> 32);
    return ((p < 0) != (q < 0)) ? -v : v;
  endfunction

  // Shape gradient sgn * 2f / d in Q16.16, saturated.
  function automatic longint node_gradient(bit minus, longint f, longint d);
    bit neg;
    longint unsigned b, q;
    longint v;
    neg = ((f < 0) != (d < 0)) != minus;
    b = (d < 0) ? -d : d;
    q = (4 * longint'((f < 0) ? -f : f) + b) / (2 * b);
    v = (q > longint'(SAT_MAX) + 1) ? SAT_MAX + 1 : longint'(q);
    v = neg ? -v : v;
    if (v > SAT_MAX) v = SAT_MAX;
    if (v < SAT_MIN) v = SAT_MIN;
    return v;
  endfunction

  // Queue the four node beats that one particle must produce.
  task automatic predict_particle(particle_t p);
    longint dx, dy, xi, eta, fx, fe, w;
    bit xi_plus, eta_plus;
    node_t n;
    dx = longint'(p.cell_x_high) - longint'(p.cell_x_low);
    dy = longint'(p.cell_y_high) - longint'(p.cell_y_low);
    for (int k = 0; k < 4; k++) begin
      n = '0;
      n.node_number = k[1:0];
      n.last_node = (k == 3);
      if (dx == 0 || dy == 0) begin
        n.degenerate = 1'b1;
      end else begin
        xi = natural_q30(2 * longint'(p.particle_x) - p.cell_x_high - p.cell_x_low, dx);
        eta = natural_q30(2 * longint'(p.particle_y) - p.cell_y_high - p.cell_y_low, dy);
        xi_plus = (k == 1 || k == 2);
        eta_plus = (k >= 2);
        fx = Q30_ONE + (xi_plus ? xi : -xi);
        fe = Q30_ONE + (eta_plus ? eta : -eta);
        w = quarter_q30(fx, fe);
        if (w < longint'(floor_model)) w = longint'(floor_model);
        if (w > 64'sh7FFF_FFFF) w = 64'sh7FFF_FFFF;
        n.weight = w[30:0];
        n.grad_x = 32'(node_gradient(!xi_plus, fe, dx));
        n.grad_y = 32'(node_gradient(!eta_plus, fx, dy));
        n.xi_coord = xi[31:0];
        n.eta_coord = eta[31:0];
      end
      pending_nodes.push_back(n);
    end
  endtask

  // Node beats read straight off the formulas: centered particle or flat cell.
  task automatic queue_typed(row_kind_t kind);
    node_t n;
    for (int k = 0; k < 4; k++) begin
      n = '0;
      n.node_number = k[1:0];
      n.last_node = (k == 3);
      if (kind == ROW_DEGENERATE) begin
        n.degenerate = 1'b1;
      end else begin
        n.weight = 31'h1000_0000;
        n.grad_x = (k == 1 || k == 2) ? 32'sh4000 : -32'sh4000;
        n.grad_y = (k >= 2) ? 32'sh4000 : -32'sh4000;
      end
      pending_nodes.push_back(n);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Compare each node beat with the oldest one owed.
  always @(posedge clk) begin
    node_t want;
    if (!rst && node_valid && !node_stall) begin
      if (pending_nodes.size() == 0) begin
        report("unexpected node beat", {30'b0, node.node_number}, '0);
      end else begin
        want = pending_nodes.pop_front();
        if (node.node_number !== want.node_number)
          report("node_number", 32'(node.node_number), 32'(want.node_number));
        if (node.weight !== want.weight)
          report("weight", 32'(node.weight), 32'(want.weight));
        if (node.grad_x !== want.grad_x) report("grad_x", node.grad_x, want.grad_x);
        if (node.grad_y !== want.grad_y) report("grad_y", node.grad_y, want.grad_y);
        if (node.xi_coord !== want.xi_coord) report("xi_coord", node.xi_coord, want.xi_coord);
        if (node.eta_coord !== want.eta_coord)
          report("eta_coord", node.eta_coord, want.eta_coord);
        if (node.degenerate !== want.degenerate)
          report("degenerate", 32'(node.degenerate), 32'(want.degenerate));
        if (node.last_node !== want.last_node)
          report("last_node", 32'(node.last_node), 32'(want.last_node));
      end
    end
  end

  // Result side: random stall before each beat, plus one long hold-off.
  always @(posedge clk) begin
    static int stall_left = 0;
    static int hold_left = 0;
    if (hold_request && hold_left == 0) begin
      hold_left = LONG_HOLD;
      hold_request <= 1'b0;
    end
    if (node_valid && !node_stall) stall_left = quiet_mode ? 0 : $urandom_range(0, 4);
    if (hold_left > 0) begin
      hold_left--;
      node_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      node_stall <= 1'b1;
    end else begin
      node_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no beat accepted on either channel and no register access.
  always @(posedge clk) begin
    if ((particle_valid && !particle_stall) || (node_valid && !node_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one particle beat after a random gap; valid stays high across beats only when the gap is zero.
  task automatic send_particle(particle_t p, row_kind_t kind);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      particle_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    particle_valid <= 1'b1;
    particle <= p;
    do @(posedge clk); while (particle_stall);
    if (kind == ROW_PREDICT) predict_particle(p);
    else queue_typed(kind);
  endtask

  task automatic drain();
    particle_valid <= 1'b0;
    while (pending_nodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_WEIGHT_FLOOR) floor_model = value[30:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic particle_t random_particle();
    particle_t p;
    int unsigned w, h;
    int mode;
    mode = $urandom_range(0, 9);
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (mode >= 2) begin
      // Well-formed cell, mostly small, particle mostly inside it.
      w = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 32'h0004_0000);
      h = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 32'h0004_0000);
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      p.cell_x_high = p.cell_x_low + w;
      p.cell_y_high = p.cell_y_low + h;
      p.particle_x = p.cell_x_low + $urandom_range(0, w);
      p.particle_y = p.cell_y_low + $urandom_range(0, h);
      if (mode == 2) p.particle_x = p.particle_x + $urandom_range(0, 2 * w);
      if (mode == 3) begin
        // Reversed cell.
        p.cell_x_high = p.cell_x_low;
        p.cell_x_low = p.cell_x_low + w;
      end
    end else if (mode == 1) begin
      if ($urandom_range(0, 1)) p.cell_x_high = p.cell_x_low;
      else p.cell_y_high = p.cell_y_low;
    end
    return p;
  endfunction

  task automatic random_phase();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_mode = (i >= 20 && i < 28);
      send_particle(random_particle(), ROW_PREDICT);
    end
    quiet_mode = 1'b0;
    drain();
  endtask

  localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  // Directed table: fields are x, y, xl, xh, yl, yh.
  stim_row_t directed[] = '{
    '{ROW_CENTER,     '{0, 0, -Q16_ONE, Q16_ONE, -Q16_ONE, Q16_ONE}},
    '{ROW_DEGENERATE, '{5, 7, Q16_ONE, Q16_ONE, 0, Q16_ONE}},
    '{ROW_DEGENERATE, '{5, 7, 0, Q16_ONE, MINV, MINV}},
    '{ROW_DEGENERATE, '{MAXV, MINV, MAXV, MAXV, MINV, MINV}},
    '{ROW_PREDICT,    '{-Q16_ONE, -Q16_ONE, -Q16_ONE, Q16_ONE, -Q16_ONE, Q16_ONE}},
    '{ROW_PREDICT,    '{Q16_ONE, Q16_ONE, -Q16_ONE, Q16_ONE, -Q16_ONE, Q16_ONE}},
    '{ROW_PREDICT,    '{Q16_ONE, -Q16_ONE, -Q16_ONE, Q16_ONE, -Q16_ONE, Q16_ONE}},
    '{ROW_PREDICT,    '{MAXV, MINV, MINV, MAXV, MINV, MAXV}},
    '{ROW_PREDICT,    '{MINV, MAXV, MINV, MAXV, MINV, MAXV}},
    '{ROW_PREDICT,    '{MAXV, MAXV, MAXV, MINV, MAXV, MINV}},
    '{ROW_PREDICT,    '{MAXV, MINV, 0, 1, 0, 1}},
    '{ROW_PREDICT,    '{1, 1, 0, 1, 0, 1}},
    '{ROW_PREDICT,    '{2 * Q16_ONE, 0, -Q16_ONE, Q16_ONE, -Q16_ONE, Q16_ONE}},
    '{ROW_PREDICT,    '{0, 0, Q16_ONE, -Q16_ONE, Q16_ONE, -Q16_ONE}},
    '{ROW_PREDICT,    '{32'sh0000_8000, 32'sh0000_4000, 0, Q16_ONE, 0, Q16_ONE}},
    '{ROW_PREDICT,    '{-1, -1, -1, -1 + 3, 0, 3}}
  };

  // Stimulus sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_particle(directed[i].p, directed[i].kind);
    drain();
    reg_write(ADDR_WEIGHT_FLOOR, 32'h4000_0000);
    random_phase();
    reg_write(ADDR_WEIGHT_FLOOR, $urandom_range(0, 32'h4000_0000));
    hold_request <= 1'b1;
    random_phase();
    reg_write(ADDR_UNMAPPED, 32'h3FFF_FFFF);
    reg_write(ADDR_WEIGHT_FLOOR, 32'h2AAA_AAAA);
    random_phase();
    reg_write(ADDR_WEIGHT_FLOOR, 32'h1555_5555);
    random_phase();
    reg_write(ADDR_WEIGHT_FLOOR, 32'h0);
    random_phase();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* bilinear_quad_shape_gradients_core.f */
rtl/bqsg_pkg.sv
rtl/bqsg_front.sv
rtl/bqsg_queue.sv
rtl/bqsg_div.sv
rtl/bqsg_back.sv
rtl/bilinear_quad_shape_gradients_core.sv
rtl/bqsg_checker.sv
dv/tb_bilinear_quad_shape_gradients_core.sv
